// ----- rtl/point_splat_gray_renderer_unit_assert.svh -----
// Assertion macros shared by the renderer RTL.
`ifndef POINT_SPLAT_GRAY_RENDERER_UNIT_ASSERT_SVH
`define POINT_SPLAT_GRAY_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PSGR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PSGR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psgr_pkg.sv -----
// Types, constants and the exponential table of the point-splat renderer.
package psgr_pkg;

  // Fixed sizes
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int EXP_DEPTH      = 256;
  localparam int IDX_W          = $clog2(EXP_DEPTH);
  localparam int MAX_HALF_WIN   = 16;
  localparam int HW_MAX         = MAX_HALF_WIN * 256;
  localparam int HW_W           = $clog2(HW_MAX + 1);
  localparam int WT_W           = 28;
  localparam int E_W            = 17;
  localparam int PROD_W         = WT_W + E_W;
  localparam int DEN_W          = 51;
  localparam int DIV_W          = 52;
  localparam int D2_W           = 44;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  // Item kinds
  localparam logic [1:0] MODE_DEPOSIT = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_WRITE   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DEPOSITED = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_READ      = 2'd2;
  localparam logic [1:0] ST_WRITE     = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_ALPHA     = 3'd2;
  localparam logic [2:0] CFG_BLUR      = 3'd3;
  localparam logic [2:0] CFG_INTENSITY = 3'd4;
  localparam logic [2:0] CFG_MIN_SIGMA = 3'd5;
  localparam logic [2:0] CFG_SCALE     = 3'd6;

  // Source of the deposit value
  typedef enum logic [1:0] {V_WT, V_SAT, V_QUOT} vsrc_e;

  // Commands from the controller
  typedef struct packed {
    logic       load_item;
    logic       setup_a;
    logic       setup_b;
    logic       setup_c;
    logic       start_pix;
    logic       v_load;
    vsrc_e      v_src;
    logic       delta;
    logic       square;
    logic       sum;
    logic       div_idx;
    logic       div_val;
    logic       e_load;
    logic       e_zero;
    logic       mul;
    logic       mem_rd_item;
    logic       mem_rd_pix;
    logic       mem_wr_item;
    logic       mem_wr_pix;
    logic       mem_clr;
    logic       blend_a;
    logic       blend_b;
    logic       advance;
    logic       out_load;
    logic [1:0] res;
  } psgr_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       rng_ok;
    logic       blur;
    logic       empty;
    logic       idx_ovf;
    logic       val_sat;
    logic       div_busy;
    logic       last_pix;
    logic       clr_last;
  } psgr_stat_t;

  // Packed exp table, entry i = exp(-8i/EXP_DEPTH) in Q1.16
  typedef logic [EXP_DEPTH-1:0][E_W-1:0] exp_tab_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] term;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      t    = (64'(i) << 30) / 64'(EXP_DEPTH);
      s    = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 31) / 64'(k);
        if ((k & 1) != 0) s = s - term;
        else s = s + term;
      end
      for (int q = 0; q < 4; q++) s = (s * s) >> 31;
      tab[i] = E_W'((s + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Signed divide by 256, rounding toward zero
  function automatic logic signed [13:0] trunc256(input logic signed [21:0] v);
    logic signed [21:0] b;
    b = v + (v[21] ? 22'sd255 : 22'sd0);
    return b[21:8];
  endfunction

endpackage

// ----- rtl/psgr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module psgr_div
  import psgr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [5:0]       nbits_i,
  input  logic [DIV_W-1:0] rem_i,   // dividend bits above the quotient span, below den
  input  logic [31:0]      lo_i,    // remaining dividend bits, MSB first
  input  logic [DIV_W-1:0] den_i,
  output logic             busy_o,
  output logic [31:0]      quot_o
);

  logic [5:0]       cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [31:0]      lo_q, lo_d, quot_q, quot_d;
  logic [DIV_W-1:0] rem_sh;

  // One shift-compare-subtract per cycle
  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    rem_sh = {rem_q[DIV_W-2:0], lo_q[31]};
    if (start_i) begin
      cnt_d  = nbits_i;
      rem_d  = rem_i;
      den_d  = den_i;
      lo_d   = lo_i;
      quot_d = '0;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      lo_d  = {lo_q[30:0], 1'b0};
      if (rem_sh >= den_q) begin
        rem_d  = rem_sh - den_q;
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quot_q;

endmodule

// ----- rtl/psgr_datapath.sv -----
// Datapath: registers, window arithmetic, pixel store and result register.
module psgr_datapath
  import psgr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic [127:0] in_data_i,
  input  logic [1:0]   in_user_i,
  input  logic         in_last_i,
  input  psgr_cmd_t    cmd_i,
  output psgr_stat_t   stat_o,
  output logic [31:0]  out_data_o,
  output logic [1:0]   out_user_o,
  output logic         out_last_o
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);

  // Configuration
  logic [8:0]         width_q, height_q;
  logic signed [15:0] alpha_q;
  logic               blur_q, blink_q;
  logic [15:0]        min_sig_q;
  logic [11:0]        scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 9'd256;
      height_q  <= 9'd256;
      alpha_q   <= '0;
      blur_q    <= 1'b0;
      blink_q   <= 1'b0;
      min_sig_q <= 16'd128;
      scale_q   <= 12'd768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:     width_q   <= cfg_data_i[8:0];
        CFG_HEIGHT:    height_q  <= cfg_data_i[8:0];
        CFG_ALPHA:     alpha_q   <= $signed(cfg_data_i);
        CFG_BLUR:      blur_q    <= cfg_data_i[0];
        CFG_INTENSITY: blink_q   <= cfg_data_i[0];
        CFG_MIN_SIGMA: min_sig_q <= cfg_data_i;
        CFG_SCALE:     scale_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Image size in use
  logic [8:0] w_eff, h_eff;
  assign w_eff = (32'(width_q) < 32'(MAX_WIDTH))   ? width_q  : 9'(MAX_WIDTH);
  assign h_eff = (32'(height_q) < 32'(MAX_HEIGHT)) ? height_q : 9'(MAX_HEIGHT);

  // Item registers
  logic [1:0]         mode_q;
  logic signed [19:0] xc_q, yc_q;
  logic [15:0]        sigma_q, pidx_q;
  logic [23:0]        photons_q;
  logic               last_q;
  logic [31:0]        wval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q    <= in_user_i;
      xc_q      <= $signed(in_data_i[19:0]);
      yc_q      <= $signed(in_data_i[39:20]);
      sigma_q   <= in_data_i[55:40];
      photons_q <= in_data_i[79:56];
      pidx_q    <= in_data_i[95:80];
      wval_q    <= in_data_i[127:96];
      last_q    <= in_last_i;
    end
  end

  logic rng_ok;
  assign rng_ok = (32'(pidx_q) < 32'(STORE));

  // Spot setup
  logic [15:0]       sig_q, sig_max;
  logic [WT_W-1:0]   wt_q;
  logic [HW_W-1:0]   hw_q;
  logic [31:0]       s2_q;
  logic [DEN_W-1:0]  den_q;
  logic [27:0]       hw_prod;
  logic [19:0]       hw_raw;

  assign sig_max = (sigma_q >= min_sig_q) ? sigma_q : min_sig_q;
  assign hw_prod = 28'(sig_q) * 28'(scale_q);
  assign hw_raw  = hw_prod[27:8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_a) begin
      sig_q <= (sig_max == 16'd0) ? 16'd1 : sig_max;
      wt_q  <= blink_q ? WT_W'(256) : {photons_q, 4'b0};
    end
    if (cmd_i.setup_b) begin
      hw_q <= (32'(hw_raw) > HW_MAX) ? HW_W'(HW_MAX) : hw_raw[HW_W-1:0];
      s2_q <= 32'(sig_q) * 32'(sig_q);
    end
    if (cmd_i.setup_c) begin
      den_q <= DEN_W'(TWO_PI_Q16) * DEN_W'(s2_q);
    end
  end

  // Window bounds and direct pixel
  logic signed [21:0] xc_ext, yc_ext, hw_ext;
  logic signed [13:0] tx0, tx1, ty0, ty1, tdx, tdy;
  logic [12:0]        x0_q, y0_q;
  logic [8:0]         x1_q, y1_q, dpx_q, dpy_q;
  logic               din_q;

  assign xc_ext = 22'(xc_q);
  assign yc_ext = 22'(yc_q);
  assign hw_ext = $signed(22'(hw_q));
  assign tx0 = trunc256(xc_ext - hw_ext);
  assign ty0 = trunc256(yc_ext - hw_ext);
  assign tx1 = trunc256(xc_ext + hw_ext + 22'sd256);
  assign ty1 = trunc256(yc_ext + hw_ext + 22'sd256);
  assign tdx = trunc256(xc_ext);
  assign tdy = trunc256(yc_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup_c) begin
      x0_q  <= tx0[13] ? 13'd0 : tx0[12:0];
      y0_q  <= ty0[13] ? 13'd0 : ty0[12:0];
      x1_q  <= tx1[13] ? 9'd0 : ((tx1[12:0] < 13'(w_eff)) ? tx1[8:0] : w_eff);
      y1_q  <= ty1[13] ? 9'd0 : ((ty1[12:0] < 13'(h_eff)) ? ty1[8:0] : h_eff);
      dpx_q <= tdx[8:0];
      dpy_q <= tdy[8:0];
      din_q <= !tdx[13] && !tdy[13] && (tdx[12:0] < 13'(w_eff)) &&
               (tdy[12:0] < 13'(h_eff));
    end
  end

  logic empty;
  assign empty = blur_q ? ((x0_q >= 13'(x1_q)) || (y0_q >= 13'(y1_q))) : !din_q;

  // Pixel walk
  logic [8:0]    px_q, py_q;
  logic [9:0]    px_nx, py_nx;
  logic [17:0]   lin;
  logic [AW-1:0] addr_q;

  assign px_nx = 10'(px_q) + 10'd1;
  assign py_nx = 10'(py_q) + 10'd1;
  assign lin   = 18'(py_q) * 18'(w_eff) + 18'(px_q);

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(lin);
    if (cmd_i.start_pix) begin
      px_q <= blur_q ? x0_q[8:0] : dpx_q;
      py_q <= blur_q ? y0_q[8:0] : dpy_q;
    end else if (cmd_i.advance) begin
      if (px_nx < 10'(x1_q)) begin
        px_q <= px_nx[8:0];
      end else begin
        px_q <= x0_q[8:0];
        py_q <= py_nx[8:0];
      end
    end
  end

  // Gaussian weight per pixel
  logic signed [21:0] dx_q, dy_q;
  logic signed [43:0] dx_sq, dy_sq;
  logic [42:0]        sqx_q, sqy_q;
  logic [D2_W-1:0]    d2_q;
  logic [E_W-1:0]     e_q;
  logic [PROD_W-1:0]  prod_q;
  logic [31:0]        v_q, quot;
  logic               div_start, div_busy;
  logic [5:0]         div_n;
  logic [DIV_W-1:0]   div_rem, div_den;
  logic [31:0]        div_lo;

  assign dx_sq = dx_q * dx_q;
  assign dy_sq = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      dx_q <= $signed({5'b0, px_q, 8'h80}) - xc_ext;
      dy_q <= $signed({5'b0, py_q, 8'h80}) - yc_ext;
    end
    if (cmd_i.square) begin
      sqx_q <= dx_sq[42:0];
      sqy_q <= dy_sq[42:0];
    end
    if (cmd_i.sum) d2_q <= D2_W'(sqx_q) + D2_W'(sqy_q);
    if (cmd_i.e_load) e_q <= cmd_i.e_zero ? '0 : EXP_TAB[quot[IDX_W-1:0]];
    if (cmd_i.mul) prod_q <= PROD_W'(wt_q) * PROD_W'(e_q);
    if (cmd_i.v_load) begin
      case (cmd_i.v_src)
        V_WT:    v_q <= 32'(wt_q);
        V_SAT:   v_q <= '1;
        default: v_q <= quot;
      endcase
    end
  end

  // Shared divider: table index first, then pixel value
  assign div_start = cmd_i.div_idx || cmd_i.div_val;
  assign div_n     = cmd_i.div_val ? 6'd32 : 6'(IDX_W);
  assign div_rem   = cmd_i.div_val ? DIV_W'(prod_q[PROD_W-1:16]) : DIV_W'(d2_q);
  assign div_lo    = cmd_i.div_val ? {prod_q[15:0], 16'b0} : 32'd0;
  assign div_den   = cmd_i.div_val ? DIV_W'(den_q) : DIV_W'({s2_q, 4'b0});

  psgr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .nbits_i (div_n),
    .rem_i   (div_rem),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // Pixel store with clearing sweep
  logic [31:0]   store_mem [STORE];
  logic [31:0]   rdata_q, wdata;
  logic [AW-1:0] clr_q, waddr, raddr;
  logic          we, re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.mem_clr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  logic [31:0] nv_q;
  assign we    = cmd_i.mem_clr || cmd_i.mem_wr_item || cmd_i.mem_wr_pix;
  assign re    = cmd_i.mem_rd_item || cmd_i.mem_rd_pix;
  assign waddr = cmd_i.mem_clr ? clr_q : (cmd_i.mem_wr_item ? AW'(pidx_q) : addr_q);
  assign wdata = cmd_i.mem_clr ? 32'd0 : (cmd_i.mem_wr_item ? wval_q : nv_q);
  assign raddr = cmd_i.mem_rd_item ? AW'(pidx_q) : addr_q;

  always_ff @(posedge clk_i) begin
    if (we) store_mem[waddr] <= wdata;
    if (re) rdata_q <= store_mem[raddr];
  end

  // Accumulate or blend
  logic [46:0] ad_prod;
  logic [31:0] d0_q;
  logic [8:0]  d1;
  logic [40:0] keep_prod;
  logic [32:0] acc_sum;
  logic [33:0] bl_sum;
  logic        accum;

  assign accum     = (alpha_q <= 16'sd0);
  assign ad_prod   = 47'(alpha_q[14:0]) * 47'(v_q);
  assign d1        = (d0_q > 32'd256) ? 9'd256 : d0_q[8:0];
  assign keep_prod = 41'(9'd256 - d1) * 41'(rdata_q);
  assign acc_sum   = 33'(rdata_q) + 33'(v_q);
  assign bl_sum    = 34'(d0_q) + 34'(keep_prod[40:8]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_a) d0_q <= (|ad_prod[46:40]) ? '1 : ad_prod[39:8];
    if (cmd_i.blend_b) begin
      if (accum) nv_q <= acc_sum[32] ? '1 : acc_sum[31:0];
      else nv_q <= (|bl_sum[33:32]) ? '1 : bl_sum[31:0];
    end
  end

  // Result register
  logic [31:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_user_q <= cmd_i.res;
      out_data_q <= (cmd_i.res == ST_READ && rng_ok) ? rdata_q : 32'd0;
      out_last_q <= (mode_q == MODE_DEPOSIT) ? last_q : 1'b0;
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;
  assign out_last_o = out_last_q;

  // Status
  assign stat_o.mode     = mode_q;
  assign stat_o.rng_ok   = rng_ok;
  assign stat_o.blur     = blur_q;
  assign stat_o.empty    = empty;
  assign stat_o.idx_ovf  = (DIV_W'(d2_q) >= DIV_W'({s2_q, 4'b0}));
  assign stat_o.val_sat  = (DIV_W'(prod_q[PROD_W-1:16]) >= DIV_W'(den_q));
  assign stat_o.div_busy = div_busy;
  assign stat_o.last_pix = (px_nx == 10'(x1_q)) && (py_nx == 10'(y1_q));
  assign stat_o.clr_last = (clr_q == AW'(STORE - 1));

endmodule

// ----- rtl/psgr_ctrl.sv -----
// Controller state machine sequencing one item at a time.
module psgr_ctrl
  import psgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  psgr_stat_t stat_i,
  output psgr_cmd_t  cmd_o
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DECODE  = 5'd2;
  localparam logic [4:0] S_SETUP_A = 5'd3;
  localparam logic [4:0] S_SETUP_B = 5'd4;
  localparam logic [4:0] S_SETUP_C = 5'd5;
  localparam logic [4:0] S_START   = 5'd6;
  localparam logic [4:0] S_ADDR    = 5'd7;
  localparam logic [4:0] S_DELTA   = 5'd8;
  localparam logic [4:0] S_SQUARE  = 5'd9;
  localparam logic [4:0] S_SUM     = 5'd10;
  localparam logic [4:0] S_IDX_CHK = 5'd11;
  localparam logic [4:0] S_DIV_I   = 5'd12;
  localparam logic [4:0] S_MUL     = 5'd13;
  localparam logic [4:0] S_VAL_CHK = 5'd14;
  localparam logic [4:0] S_DIV_V   = 5'd15;
  localparam logic [4:0] S_RD      = 5'd16;
  localparam logic [4:0] S_BL_A    = 5'd17;
  localparam logic [4:0] S_BL_B    = 5'd18;
  localparam logic [4:0] S_WR      = 5'd19;
  localparam logic [4:0] S_RESP    = 5'd20;

  logic [4:0] state_q, state_d;
  logic [1:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    cmd_o       = '0;
    cmd_o.v_src = V_WT;
    cmd_o.res   = res_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.mode)
          MODE_DEPOSIT: state_d = S_SETUP_A;
          MODE_READ: begin
            cmd_o.mem_rd_item = stat_i.rng_ok;
            res_d             = ST_READ;
            state_d           = S_RESP;
          end
          MODE_WRITE: begin
            cmd_o.mem_wr_item = stat_i.rng_ok;
            res_d             = ST_WRITE;
            state_d           = S_RESP;
          end
          default: begin
            res_d   = ST_DROPPED;
            state_d = S_RESP;
          end
        endcase
      end
      S_SETUP_A: begin
        cmd_o.setup_a = 1'b1;
        state_d       = S_SETUP_B;
      end
      S_SETUP_B: begin
        cmd_o.setup_b = 1'b1;
        state_d       = S_SETUP_C;
      end
      S_SETUP_C: begin
        cmd_o.setup_c = 1'b1;
        state_d       = S_START;
      end
      S_START: begin
        if (stat_i.empty) begin
          res_d   = ST_DROPPED;
          state_d = S_RESP;
        end else begin
          cmd_o.start_pix = 1'b1;
          res_d           = ST_DEPOSITED;
          state_d         = stat_i.blur ? S_DELTA : S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.v_load = 1'b1;
        cmd_o.v_src  = V_WT;
        state_d      = S_RD;
      end
      S_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_IDX_CHK;
      end
      S_IDX_CHK: begin
        if (stat_i.idx_ovf) begin
          cmd_o.e_load = 1'b1;
          cmd_o.e_zero = 1'b1;
          state_d      = S_MUL;
        end else begin
          cmd_o.div_idx = 1'b1;
          state_d       = S_DIV_I;
        end
      end
      S_DIV_I: begin
        if (!stat_i.div_busy) begin
          cmd_o.e_load = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_VAL_CHK;
      end
      S_VAL_CHK: begin
        if (stat_i.val_sat) begin
          cmd_o.v_load = 1'b1;
          cmd_o.v_src  = V_SAT;
          state_d      = S_RD;
        end else begin
          cmd_o.div_val = 1'b1;
          state_d       = S_DIV_V;
        end
      end
      S_DIV_V: begin
        if (!stat_i.div_busy) begin
          cmd_o.v_load = 1'b1;
          cmd_o.v_src  = V_QUOT;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd_pix = 1'b1;
        state_d          = S_BL_A;
      end
      S_BL_A: begin
        cmd_o.blend_a = 1'b1;
        state_d       = S_BL_B;
      end
      S_BL_B: begin
        cmd_o.blend_b = 1'b1;
        state_d       = S_WR;
      end
      S_WR: begin
        cmd_o.mem_wr_pix = 1'b1;
        cmd_o.advance    = 1'b1;
        state_d          = (!stat_i.blur || stat_i.last_pix) ? S_RESP : S_DELTA;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_q       <= ST_DEPOSITED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/point_splat_gray_renderer_unit.sv -----
// Top level of the grayscale point-splat renderer.
//
//  port group   dir  sync        payload
//  s_axis_*     in   tvalid/rdy  tuser mode, tlast last_in_batch, tdata fields
//  m_axis_*     out  tvalid/rdy  tuser status, tlast batch_done, tdata read_value
//  cfg_*        in   write en    cfg_idx_i register index, cfg_data_i value
//
// One item at a time, from the accept cycle to the result load. Read, write
// and undefined items, dropped deposits and direct deposits do not use the
// divider; a blurred deposit runs every window pixel through the shared
// one-bit-per-cycle divider, table index first, then pixel value; either
// division is skipped when it would overflow or saturate.
// After reset all MAX_WIDTH*MAX_HEIGHT words of the store (65536 by default)
// are cleared one word a cycle; s_axis_tready stays low until the clear is done.
// A result waits in the output register while the next item is accepted;
// a finished item stalls until that register is free.
`include "point_splat_gray_renderer_unit_assert.svh"
module point_splat_gray_renderer_unit
  import psgr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // loc_x[19:0], loc_y[39:20], sigma[55:40], photons[79:56],
  // pixel_index[95:80], write_value[127:96]
  input  logic [127:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // mode[1:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // read_value[31:0]
  output logic [1:0]   m_axis_tuser,  // status[1:0]
  output logic         m_axis_tlast
);

  psgr_cmd_t  cmd;
  psgr_stat_t stat;

  psgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  psgr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  // A waiting result is never overwritten
  `PSGR_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten")
  // An accepted item closes the input until it is finished
  `PSGR_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken")
  // The divider is only started when idle
  `PSGR_ASSERT_NOW(a_div_idle, clk_i, rst_ni, cmd.div_idx || cmd.div_val, !stat.div_busy, "divider restarted")

endmodule
